@@ design/scancode_set1_to_ascii_defines.svh @@
// Assertion macros for the translator RTL.
`ifndef SCANCODE_SET1_TO_ASCII_DEFINES_SVH
`define SCANCODE_SET1_TO_ASCII_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SC1A_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define SC1A_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ design/sc1a_pkg.sv @@
package sc1a_pkg;

  localparam int unsigned CharW = 7;
  localparam int unsigned MaxBytes = 3;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_PREFIX       = 8'hE0;
  localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
  localparam logic [7:0] SC_UP           = 8'h48;
  localparam logic [7:0] SC_DOWN         = 8'h50;
  localparam logic [7:0] SC_RIGHT        = 8'h4D;
  localparam logic [7:0] SC_LEFT         = 8'h4B;
  localparam logic [7:0] TABLE_LEN       = 8'd58;

  localparam logic [6:0] ASCII_ESC      = 7'h1B;
  localparam logic [6:0] ASCII_LBRACKET = 7'h5B;
  localparam logic [6:0] ASCII_A        = 7'h41;
  localparam logic [6:0] ASCII_B        = 7'h42;
  localparam logic [6:0] ASCII_C        = 7'h43;
  localparam logic [6:0] ASCII_D        = 7'h44;
  localparam logic [6:0] ASCII_LOWER_A  = 7'h61;
  localparam logic [6:0] ASCII_LOWER_Z  = 7'h7A;
  localparam logic [6:0] CTRL_OFFSET    = 7'h60;

  localparam logic [6:0] PLAIN_MAP [58] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
    7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  localparam logic [6:0] UPPER_MAP [58] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
    7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  typedef struct packed {
    logic [1:0]                  len;
    logic [MaxBytes-1:0][CharW-1:0] bytes;
  } run_t;

endpackage

@@ design/scancode_set1_to_ascii.sv @@
// Scancode set 1 to ASCII translator.
// Input channel: in_valid/in_ready with one raw set-1 byte on scancode.
// Output channel: out_valid/out_ready with out_char and is_last; is_last
// marks the final byte of the run caused by one scancode.
// Modifier and prefix codes, releases and unmapped keys produce no bytes
// (an unmapped key gives a lone ESC when alt is held). A key yields one or
// two bytes (ESC before it when alt is held), an extended arrow three (ESC '[' letter).
// Path: the first byte of a run passes the run queue, the emitter's run
// register and the output register. Throughput: one output byte per cycle
// while the receiver takes them; the single output register drains the
// run queue. Scancodes with no output never enter the queue.
// A run queue of QUEUE_DEPTH entries sits between the decoder and the
// emitter; in_ready drops only while it is full.
// Reset clears shift, ctrl, alt, the pending prefix, the queue and
// out_valid. When the receiver stalls, the output byte holds, the queue
// fills, and then input stalls; no state is lost.
module scancode_set1_to_ascii #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scancode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       is_last
);

  logic           push, push_ready, run_valid, pop;
  sc1a_pkg::run_t push_run, pop_run;

  sc1a_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .scancode   (scancode),
    .push       (push),
    .push_ready (push_ready),
    .run        (push_run)
  );

  sc1a_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_run   (push_run),
    .pop_valid  (run_valid),
    .pop        (pop),
    .pop_run    (pop_run)
  );

  sc1a_back u_back (
    .clk       (clk),
    .rst       (rst),
    .run_valid (run_valid),
    .pop       (pop),
    .run       (pop_run),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .is_last   (is_last)
  );

endmodule

@@ design/sc1a_front.sv @@
module sc1a_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        scancode,
  output logic              push,
  input  logic              push_ready,
  output sc1a_pkg::run_t    run
);

  logic shift_held, ctrl_held, alt_held, prefix_pending;
  logic shift_next, ctrl_next, alt_next, prefix_next;
  logic accept;
  logic [6:0] ch;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign push     = accept && (run.len != 2'd0);

  always_comb begin
    shift_next  = shift_held;
    ctrl_next   = ctrl_held;
    alt_next    = alt_held;
    prefix_next = prefix_pending;
    run         = '0;
    ch          = '0;
    priority if (scancode == sc1a_pkg::SC_LSHIFT_MAKE ||
                 scancode == sc1a_pkg::SC_RSHIFT_MAKE) begin
      shift_next = 1'b1;
    end else if (scancode == sc1a_pkg::SC_LSHIFT_BREAK ||
                 scancode == sc1a_pkg::SC_RSHIFT_BREAK) begin
      shift_next = 1'b0;
    end else if (scancode == sc1a_pkg::SC_PREFIX) begin
      prefix_next = 1'b1;
    end else if (scancode == sc1a_pkg::SC_CTRL_MAKE) begin
      ctrl_next   = 1'b1;
      prefix_next = 1'b0;
    end else if (scancode == sc1a_pkg::SC_CTRL_BREAK) begin
      ctrl_next   = 1'b0;
      prefix_next = 1'b0;
    end else if (scancode == sc1a_pkg::SC_ALT_MAKE) begin
      alt_next    = 1'b1;
      prefix_next = 1'b0;
    end else if (scancode == sc1a_pkg::SC_ALT_BREAK) begin
      alt_next    = 1'b0;
      prefix_next = 1'b0;
    end else if (scancode[7]) begin
      prefix_next = 1'b0;
    end else if (prefix_pending) begin
      prefix_next  = 1'b0;
      run.bytes[0] = sc1a_pkg::ASCII_ESC;
      run.bytes[1] = sc1a_pkg::ASCII_LBRACKET;
      priority if (scancode == sc1a_pkg::SC_UP) begin
        run.bytes[2] = sc1a_pkg::ASCII_A;
        run.len      = 2'd3;
      end else if (scancode == sc1a_pkg::SC_DOWN) begin
        run.bytes[2] = sc1a_pkg::ASCII_B;
        run.len      = 2'd3;
      end else if (scancode == sc1a_pkg::SC_RIGHT) begin
        run.bytes[2] = sc1a_pkg::ASCII_C;
        run.len      = 2'd3;
      end else if (scancode == sc1a_pkg::SC_LEFT) begin
        run.bytes[2] = sc1a_pkg::ASCII_D;
        run.len      = 2'd3;
      end else begin
        run.len = 2'd0;
      end
    end else begin
      if (scancode < sc1a_pkg::TABLE_LEN) begin
        ch = shift_held ? sc1a_pkg::UPPER_MAP[scancode[5:0]]
                        : sc1a_pkg::PLAIN_MAP[scancode[5:0]];
      end
      if (ctrl_held && ch >= sc1a_pkg::ASCII_LOWER_A && ch <= sc1a_pkg::ASCII_LOWER_Z) begin
        ch = ch - sc1a_pkg::CTRL_OFFSET;
      end
      if (alt_held) begin
        run.bytes[0] = sc1a_pkg::ASCII_ESC;
        run.bytes[1] = ch;
        run.len      = (ch != 7'd0) ? 2'd2 : 2'd1;
      end else begin
        run.bytes[0] = ch;
        run.len      = (ch != 7'd0) ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      ctrl_held      <= 1'b0;
      alt_held       <= 1'b0;
      prefix_pending <= 1'b0;
    end else if (accept) begin
      shift_held     <= shift_next;
      ctrl_held      <= ctrl_next;
      alt_held       <= alt_next;
      prefix_pending <= prefix_next;
    end
  end

endmodule

@@ design/sc1a_queue.sv @@
module sc1a_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  sc1a_pkg::run_t push_run,
  output logic           pop_valid,
  input  logic           pop,
  output sc1a_pkg::run_t pop_run
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  sc1a_pkg::run_t  mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign push_ready = (count != FullCnt);
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_run    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CntW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CntW'(count - 1'b1);
      end
    end
  end

endmodule

@@ design/sc1a_back.sv @@
`include "scancode_set1_to_ascii_defines.svh"

module sc1a_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           run_valid,
  output logic           pop,
  input  sc1a_pkg::run_t run,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_char,
  output logic           is_last
);

  sc1a_pkg::run_t cur;
  logic       busy;
  logic [1:0] idx;
  logic       out_free, emit, last_byte;

  assign out_free  = !out_valid || out_ready;
  assign emit      = busy && out_free;
  assign last_byte = (idx == 2'(cur.len - 2'd1));
  assign pop       = run_valid && (!busy || (emit && last_byte));

  // Load the next run as the last byte of the current one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (emit && last_byte) begin
      busy <= 1'b0;
    end else if (emit) begin
      idx <= 2'(idx + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= cur.bytes[idx];
      is_last  <= last_byte;
    end
  end

  `SC1A_ASSERT(a_idx_in_run, !busy || (cur.len != 2'd0 && idx < cur.len), "byte index past run")
  `SC1A_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !is_last, out_valid, "gap in run")
  `SC1A_ASSERT(a_pop_at_end, !pop || !busy || (emit && last_byte), "run popped while busy")

endmodule

@@ tb/sv/scancode_set1_to_ascii_tb.sv @@
module scancode_set1_to_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned KEYS_PER_PHASE = 15;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } ascii_byte_t;

  typedef struct {
    logic [7:0]  code;
    int unsigned phase;
    bit          drain;
  } code_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] scancode = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       is_last;

  code_item_t  scancode_q[$];
  ascii_byte_t ascii_q[$];

  logic shift_down = 1'b0;
  logic ctrl_down = 1'b0;
  logic alt_down = 1'b0;
  logic ext_pending = 1'b0;

  logic [6:0] lower_keys [0:57] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
    7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  logic [6:0] upper_keys [0:57] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
    7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  int unsigned send_idle [3] = '{24, 49, 0};
  int unsigned recv_idle [3] = '{49, 24, 0};

  int unsigned fill_phase = 0;
  bit          fill_drain = 1'b0;
  int unsigned cur_phase = 0;
  int unsigned in_count = 0;
  int unsigned hold_at = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          in_took = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  scancode_set1_to_ascii i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .scancode  (scancode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .is_last   (is_last)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void translate_code(input logic [7:0] code);
    logic [6:0] run [3];
    int         n;
    logic [6:0] ch;
    logic [6:0] arrow;
    n = 0;
    ch = '0;
    arrow = '0;
    if (code == sc1a_pkg::SC_LSHIFT_MAKE || code == sc1a_pkg::SC_RSHIFT_MAKE) begin
      shift_down = 1'b1;
    end else if (code == sc1a_pkg::SC_LSHIFT_BREAK || code == sc1a_pkg::SC_RSHIFT_BREAK) begin
      shift_down = 1'b0;
    end else if (code == sc1a_pkg::SC_PREFIX) begin
      ext_pending = 1'b1;
    end else if (code == sc1a_pkg::SC_CTRL_MAKE || code == sc1a_pkg::SC_CTRL_BREAK) begin
      ctrl_down = (code == sc1a_pkg::SC_CTRL_MAKE);
      ext_pending = 1'b0;
    end else if (code == sc1a_pkg::SC_ALT_MAKE || code == sc1a_pkg::SC_ALT_BREAK) begin
      alt_down = (code == sc1a_pkg::SC_ALT_MAKE);
      ext_pending = 1'b0;
    end else if (code[7]) begin
      ext_pending = 1'b0;
    end else if (ext_pending) begin
      ext_pending = 1'b0;
      case (code)
        sc1a_pkg::SC_UP:    arrow = sc1a_pkg::ASCII_A;
        sc1a_pkg::SC_DOWN:  arrow = sc1a_pkg::ASCII_B;
        sc1a_pkg::SC_RIGHT: arrow = sc1a_pkg::ASCII_C;
        sc1a_pkg::SC_LEFT:  arrow = sc1a_pkg::ASCII_D;
        default:            arrow = '0;
      endcase
      if (arrow != '0) begin
        run[0] = sc1a_pkg::ASCII_ESC;
        run[1] = sc1a_pkg::ASCII_LBRACKET;
        run[2] = arrow;
        n = 3;
      end
    end else begin
      if (code < sc1a_pkg::TABLE_LEN) begin
        ch = shift_down ? upper_keys[code[5:0]] : lower_keys[code[5:0]];
      end
      if (ctrl_down && ch >= sc1a_pkg::ASCII_LOWER_A && ch <= sc1a_pkg::ASCII_LOWER_Z) begin
        ch = ch - sc1a_pkg::CTRL_OFFSET;
      end
      if (alt_down) begin
        run[n] = sc1a_pkg::ASCII_ESC;
        n++;
      end
      if (ch != '0) begin
        run[n] = ch;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      ascii_q.push_back({run[i], i == n - 1});
    end
  endfunction

  task automatic queue_code(input logic [7:0] code);
    code_item_t item;
    item.code = code;
    item.phase = fill_phase;
    item.drain = fill_drain;
    fill_drain = 1'b0;
    scancode_q.push_back(item);
  endtask

  function automatic logic [7:0] pick_modifier();
    case ($urandom_range(7))
      0: return sc1a_pkg::SC_LSHIFT_MAKE;
      1: return sc1a_pkg::SC_LSHIFT_BREAK;
      2: return sc1a_pkg::SC_RSHIFT_MAKE;
      3: return sc1a_pkg::SC_RSHIFT_BREAK;
      4: return sc1a_pkg::SC_CTRL_MAKE;
      5: return sc1a_pkg::SC_CTRL_BREAK;
      6: return sc1a_pkg::SC_ALT_MAKE;
      default: return sc1a_pkg::SC_ALT_BREAK;
    endcase
  endfunction

  // Mostly well-formed key and arrow sequences, some noise and broken prefixes.
  task automatic queue_random_keys(input int unsigned keys);
    int unsigned done_keys;
    logic [7:0]  code;
    done_keys = 0;
    while (done_keys < keys) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          if ($urandom_range(7) == 0) begin
            code = 8'($urandom_range(127, 58));
          end else begin
            code = 8'($urandom_range(57));
          end
          queue_code(code);
          done_keys++;
        end
        4: begin
          queue_code(pick_modifier());
        end
        5, 6: begin
          queue_code(sc1a_pkg::SC_PREFIX);
          case ($urandom_range(3))
            0: queue_code(sc1a_pkg::SC_UP);
            1: queue_code(sc1a_pkg::SC_DOWN);
            2: queue_code(sc1a_pkg::SC_RIGHT);
            default: queue_code(sc1a_pkg::SC_LEFT);
          endcase
          done_keys++;
        end
        7: begin
          queue_code(sc1a_pkg::SC_PREFIX);
          case ($urandom_range(3))
            0: code = 8'($urandom_range(127));
            1: code = 8'($urandom_range(255, 128));
            2: code = $urandom_range(1) ? sc1a_pkg::SC_CTRL_MAKE : sc1a_pkg::SC_ALT_BREAK;
            default: code = pick_modifier();
          endcase
          queue_code(code);
          done_keys++;
        end
        8: begin
          code = 8'($urandom_range(255, 128));
          queue_code(code);
        end
        default: begin
          code = 8'($urandom);
          queue_code(code);
        end
      endcase
    end
  endtask

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (scancode_q.size() != 0 && (!scancode_q[0].drain || ascii_q.size() == 0) &&
          $urandom_range(99) >= send_idle[scancode_q[0].phase]) begin
        cur_phase <= scancode_q[0].phase;
        scancode <= scancode_q[0].code;
        in_valid <= 1'b1;
        void'(scancode_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Hold off the receiver once for long enough to fill the block.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && in_count >= hold_at) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle[cur_phase]);
    end
  end

  always @(posedge clk) begin
    ascii_byte_t want;
    in_took = 1'b0;
    if (!rst) begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        in_count++;
        quiet_cycles = 0;
        translate_code(scancode);
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (ascii_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte out_char=%h is_last=%b", out_char,
                                    is_last));
        end else begin
          want = ascii_q.pop_front();
          if (out_char !== want.ch) begin
            report_mismatch($sformatf("out_char %h, expected %h", out_char, want.ch));
          end
          if (is_last !== want.last) begin
            report_mismatch($sformatf("is_last %b, expected %b", is_last, want.last));
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    queue_code(8'h00);
    queue_code(8'h39);
    queue_code(8'h7F);
    queue_code(8'hFF);
    queue_code(sc1a_pkg::SC_LSHIFT_MAKE);
    queue_code(8'h1E);
    queue_code(sc1a_pkg::SC_RSHIFT_BREAK);
    queue_code(sc1a_pkg::SC_CTRL_MAKE);
    queue_code(8'h2C);
    queue_code(sc1a_pkg::SC_ALT_MAKE);
    queue_code(8'h00);
    queue_code(sc1a_pkg::SC_CTRL_BREAK);
    queue_code(sc1a_pkg::SC_ALT_BREAK);
    queue_code(sc1a_pkg::SC_PREFIX);
    queue_code(sc1a_pkg::SC_UP);
    queue_code(sc1a_pkg::SC_PREFIX);
    queue_code(sc1a_pkg::SC_DOWN);
    queue_code(sc1a_pkg::SC_PREFIX);
    queue_code(sc1a_pkg::SC_RIGHT);
    queue_code(sc1a_pkg::SC_PREFIX);
    queue_code(sc1a_pkg::SC_LEFT);
    queue_code(sc1a_pkg::SC_PREFIX);
    queue_code(sc1a_pkg::SC_RSHIFT_MAKE);
    queue_code(8'h1E);
    queue_code(sc1a_pkg::SC_LSHIFT_BREAK);

    queue_random_keys(KEYS_PER_PHASE);
    fill_phase = 1;
    fill_drain = 1'b1;
    queue_random_keys(KEYS_PER_PHASE);
    fill_phase = 2;
    fill_drain = 1'b1;
    hold_at = scancode_q.size() + 4;
    queue_random_keys(KEYS_PER_PHASE);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (scancode_q.size() != 0 || in_valid || ascii_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (ascii_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never arrived", ascii_q.size()));
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
